@@ rtl/core/kdq_pkg.sv @@
// Package for the keyword detection qualifier: field widths, register map,
// verdict kinds and the structs passed between the front, queue and back.
// No dependencies.
package kdq_pkg;

  localparam int CLASS_W    = 4;
  localparam int PROB_W     = 16;
  localparam int WEIGHT_W   = 17;
  localparam int LEN_W      = 8;
  localparam int COUNT_W    = 9;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Q0.16 one and rounding half
  localparam logic [WEIGHT_W-1:0] Q16_ONE    = 17'h10000;
  localparam logic [PROB_W-1:0]   ROUND_HALF = 16'h8000;

  // Register reset values
  localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RST    = 17'd19661;
  localparam logic [PROB_W-1:0]   THRESHOLD_RST     = 16'd52429;
  localparam logic [LEN_W-1:0]    RUN_LENGTH_RST    = 8'd10;
  localparam logic [LEN_W-1:0]    HOLDOFF_RST       = 8'd10;
  localparam logic [CLASS_W-1:0]  OTHER_INDEX_RST   = 4'd0;
  localparam logic [CLASS_W-1:0]  SILENCE_INDEX_RST = 4'd1;

  // Register map, word index into the APB space
  typedef enum logic [2:0] {
    REG_EMA_WEIGHT     = 3'd0,
    REG_DETECT_THRESH  = 3'd1,
    REG_RUN_LENGTH     = 3'd2,
    REG_HOLDOFF_LENGTH = 3'd3,
    REG_OTHER_INDEX    = 3'd4,
    REG_SILENCE_INDEX  = 3'd5
  } reg_idx_t;

  // What the front decided about a verdict
  typedef enum logic [1:0] {
    KIND_IGNORE   = 2'd0,
    KIND_NEW_RUN  = 2'd1,
    KIND_CONTINUE = 2'd2
  } verdict_kind_t;

  typedef struct packed {
    verdict_kind_t        kind;
    logic [CLASS_W-1:0]   cls;
    logic [PROB_W-1:0]    prob;
  } verdict_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0]  ema_weight;
    logic [PROB_W-1:0]    detect_threshold;
    logic [LEN_W-1:0]     run_length;
    logic [LEN_W-1:0]     holdoff_length;
    logic [CLASS_W-1:0]   other_index;
    logic [CLASS_W-1:0]   silence_index;
  } cfg_t;

  typedef struct packed {
    logic                 detected;
    logic [CLASS_W-1:0]   cls;
    logic [PROB_W-1:0]    avg;
  } result_t;

endpackage

@@ rtl/core/kdq_queue.sv @@
// Short verdict queue between the classifying front and the filter back.
// Depends on kdq_pkg (verdict_t).
module kdq_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kdq_pkg::verdict_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output kdq_pkg::verdict_t head_data
);
  import kdq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  verdict_t           mem_r [DEPTH];
  logic [IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // Pointer advance with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

endmodule

@@ rtl/core/kdq_front.sv @@
// Front of the qualifier: accepts verdicts and tags each one as ignored,
// start of a new run or continuation of the current run.
// Depends on kdq_pkg (verdict_t, verdict_kind_t).
module kdq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kdq_pkg::CLASS_W-1:0]  in_cls,
  input  logic [kdq_pkg::PROB_W-1:0]   in_prob,
  input  logic [kdq_pkg::CLASS_W-1:0]  other_index,
  input  logic [kdq_pkg::CLASS_W-1:0]  silence_index,
  input  logic                         queue_full,
  output logic                         push,
  output kdq_pkg::verdict_t            push_data
);
  import kdq_pkg::*;

  logic [CLASS_W-1:0] prev_class_r, prev_class_nxt;
  logic               ignored;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;
  assign ignored  = (in_cls == other_index) || (in_cls == silence_index);

  // Classify; the last non-ignored class marks run boundaries
  always_comb begin
    prev_class_nxt  = prev_class_r;
    push_data.cls   = in_cls;
    push_data.prob  = in_prob;
    if (ignored) begin
      push_data.kind = KIND_IGNORE;
    end else if (in_cls != prev_class_r) begin
      push_data.kind = KIND_NEW_RUN;
      prev_class_nxt = in_cls;
    end else begin
      push_data.kind = KIND_CONTINUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_class_r <= '0;
    end else if (push) begin
      prev_class_r <= prev_class_nxt;
    end
  end

endmodule

@@ rtl/core/kdq_back.sv @@
// Back of the qualifier: run counter, Q0.16 moving average, detection
// decision and the output register. Depends on kdq_pkg.
module kdq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  kdq_pkg::cfg_t     cfg,
  input  logic              head_valid,
  input  kdq_pkg::verdict_t head_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output kdq_pkg::result_t  out_result
);
  import kdq_pkg::*;

  logic signed [COUNT_W-1:0]   run_count_r, run_count_nxt;
  logic [PROB_W-1:0]           avg_r, avg_nxt;
  logic                        out_valid_r;
  result_t                     result_r, result_nxt;

  logic [PROB_W-1:0]           avg_base;
  logic signed [COUNT_W-1:0]   count_base;
  logic signed [COUNT_W:0]     count_inc;
  logic signed [COUNT_W:0]     run_len_s;
  logic signed [COUNT_W:0]     count_sat;
  logic [WEIGHT_W-1:0]         weight;
  logic signed [PROB_W:0]      diff;
  logic signed [WEIGHT_W+PROB_W+1:0] prod;
  logic signed [WEIGHT_W+PROB_W+2:0] acc;
  logic [PROB_W-1:0]           blended;
  logic                        hit;

  assign pop = head_valid && (!out_valid_r || out_ready);

  // Average update as avg + w*(p - avg): one multiplier, rounded half up
  always_comb begin
    avg_base   = (head_data.kind == KIND_NEW_RUN) ? '0 : avg_r;
    count_base = (head_data.kind == KIND_NEW_RUN) ? '0 : run_count_r;
    weight     = (cfg.ema_weight > Q16_ONE) ? Q16_ONE : cfg.ema_weight;
    diff       = $signed({1'b0, head_data.prob}) - $signed({1'b0, avg_base});
    prod       = $signed({1'b0, weight}) * diff;
    acc        = $signed({3'b000, avg_base, 16'h0000}) + (WEIGHT_W+PROB_W+3)'(prod)
                 + $signed({20'h00000, ROUND_HALF});
    blended    = acc[PROB_W+15:16];
  end

  // Run count with saturation at the run length
  always_comb begin
    count_inc = (COUNT_W+1)'(count_base) + (COUNT_W+1)'(1);
    run_len_s = $signed({2'b00, cfg.run_length});
    count_sat = (count_inc > run_len_s) ? run_len_s : count_inc;
    hit       = (count_sat >= run_len_s) && (blended >= cfg.detect_threshold);
  end

  // Next state and next result
  always_comb begin
    run_count_nxt = run_count_r;
    avg_nxt       = avg_r;
    result_nxt    = '0;
    case (head_data.kind)
      KIND_IGNORE: begin
        run_count_nxt = '0;
        avg_nxt       = '0;
      end
      KIND_NEW_RUN, KIND_CONTINUE: begin
        if (hit) begin
          run_count_nxt       = -$signed({1'b0, cfg.holdoff_length});
          avg_nxt             = '0;
          result_nxt.detected = 1'b1;
          result_nxt.cls      = head_data.cls;
          result_nxt.avg      = blended;
        end else begin
          run_count_nxt = count_sat[COUNT_W-1:0];
          avg_nxt       = blended;
        end
      end
      default: begin
        run_count_nxt = run_count_r;
        avg_nxt       = avg_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_count_r <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        run_count_r <= run_count_nxt;
        avg_r       <= avg_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

@@ rtl/core/keyword_detection_qualifier.sv @@
// Keyword detection qualifier top level: APB register file, front, queue, back.
// Depends on kdq_pkg, kdq_front, kdq_queue, kdq_back.
//
// Takes one classifier verdict per cycle while the queue is not full and
// returns exactly one result per verdict, in order. An accepted verdict is
// tagged by the front and written to the queue. The back reads it from the
// queue head once the output register is free or being taken, updates the run
// count and moving average, and loads the output register, which drives
// out_tvalid. Sustained rate is one verdict per cycle while out_tready stays
// high, set by the average update in the back (one 17x17 multiply feeding its
// own register). The queue of QUEUE_DEPTH entries absorbs stalls on the result
// side; in_tready drops only when it is full. The user must write registers
// only while no verdict is in flight; the block does not enforce this.
module keyword_detection_qualifier #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [3:0] class index, [19:4] class probability, [23:20] zero
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [kdq_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: [3:0] detected_class, [19:4] average_probability, [23:20] zero
  // out_tuser: [0] detected
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [kdq_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [kdq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [kdq_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [kdq_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import kdq_pkg::*;

  cfg_t      cfg_r;
  logic      cfg_wr;
  reg_idx_t  cfg_idx;

  logic      push, queue_full, pop, head_valid;
  verdict_t  push_data, head_data;
  result_t   result;

  // Register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ema_weight       <= EMA_WEIGHT_RST;
      cfg_r.detect_threshold <= THRESHOLD_RST;
      cfg_r.run_length       <= RUN_LENGTH_RST;
      cfg_r.holdoff_length   <= HOLDOFF_RST;
      cfg_r.other_index      <= OTHER_INDEX_RST;
      cfg_r.silence_index    <= SILENCE_INDEX_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_EMA_WEIGHT:     cfg_r.ema_weight       <= cfg_pwdata[WEIGHT_W-1:0];
        REG_DETECT_THRESH:  cfg_r.detect_threshold <= cfg_pwdata[PROB_W-1:0];
        REG_RUN_LENGTH:     cfg_r.run_length       <= cfg_pwdata[LEN_W-1:0];
        REG_HOLDOFF_LENGTH: cfg_r.holdoff_length   <= cfg_pwdata[LEN_W-1:0];
        REG_OTHER_INDEX:    cfg_r.other_index      <= cfg_pwdata[CLASS_W-1:0];
        REG_SILENCE_INDEX:  cfg_r.silence_index    <= cfg_pwdata[CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (cfg_idx)
      REG_EMA_WEIGHT:     cfg_prdata = CFG_DATA_W'(cfg_r.ema_weight);
      REG_DETECT_THRESH:  cfg_prdata = CFG_DATA_W'(cfg_r.detect_threshold);
      REG_RUN_LENGTH:     cfg_prdata = CFG_DATA_W'(cfg_r.run_length);
      REG_HOLDOFF_LENGTH: cfg_prdata = CFG_DATA_W'(cfg_r.holdoff_length);
      REG_OTHER_INDEX:    cfg_prdata = CFG_DATA_W'(cfg_r.other_index);
      REG_SILENCE_INDEX:  cfg_prdata = CFG_DATA_W'(cfg_r.silence_index);
      default:            cfg_prdata = '0;
    endcase
  end

  kdq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_cls        (in_tdata[CLASS_W-1:0]),
    .in_prob       (in_tdata[CLASS_W+PROB_W-1:CLASS_W]),
    .other_index   (cfg_r.other_index),
    .silence_index (cfg_r.silence_index),
    .queue_full    (queue_full),
    .push          (push),
    .push_data     (push_data)
  );

  kdq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  kdq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  assign out_tuser = result.detected;
  assign out_tdata = {(OUT_DATA_W-CLASS_W-PROB_W)'(0), result.avg, result.cls};

endmodule

@@ rtl/core/kdq_checker.sv @@
// Port-level checker for the keyword detection qualifier, bound to the top.
// Depends on kdq_pkg and keyword_detection_qualifier.
module kdq_checker #(
  parameter int QUEUE_DEPTH = 4
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [kdq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);
  import kdq_pkg::*;

  localparam int PEND_W = $clog2(QUEUE_DEPTH + 3);

  logic              in_xfer, out_xfer;
  logic [PEND_W-1:0] pending_r;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // Transactions accepted whose result is not yet taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_r <= pending_r + 1'b1;
    end else if (!in_xfer && out_xfer) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // No detection means an all-zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("non-detection result carries data");

  // Every result belongs to an accepted verdict
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != '0)
    else $error("result without a pending verdict");

  // In-flight verdicts bounded by queue plus output register
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= PEND_W'(QUEUE_DEPTH + 1))
    else $error("more verdicts in flight than storage allows");

endmodule

bind keyword_detection_qualifier kdq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_kdq_checker (.*);

@@ bench/tb_keyword_detection_qualifier.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for keyword_detection_qualifier: streams classifier verdicts,
// predicts each detection result in a scoreboard class and compares in order.
// Depends on kdq_pkg and the keyword_detection_qualifier RTL.
module tb_keyword_detection_qualifier;
  import kdq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Predicts the result of every accepted verdict and checks the returned ones
  class detection_scoreboard;
    cfg_t                        regs;
    logic [CLASS_W-1:0]          last_cls;
    logic signed [COUNT_W-1:0]   run_cnt;
    logic [PROB_W-1:0]           smoothed;
    result_t                     pending_results[$];
    int                          n_checked;
    int                          n_detections;
    int                          n_mismatches;

    function new();
      regs.ema_weight       = EMA_WEIGHT_RST;
      regs.detect_threshold = THRESHOLD_RST;
      regs.run_length       = RUN_LENGTH_RST;
      regs.holdoff_length   = HOLDOFF_RST;
      regs.other_index      = OTHER_INDEX_RST;
      regs.silence_index    = SILENCE_INDEX_RST;
      last_cls     = '0;
      run_cnt      = '0;
      smoothed     = '0;
      n_checked    = 0;
      n_detections = 0;
      n_mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_EMA_WEIGHT:     regs.ema_weight       = value[WEIGHT_W-1:0];
        REG_DETECT_THRESH:  regs.detect_threshold = value[PROB_W-1:0];
        REG_RUN_LENGTH:     regs.run_length       = value[LEN_W-1:0];
        REG_HOLDOFF_LENGTH: regs.holdoff_length   = value[LEN_W-1:0];
        REG_OTHER_INDEX:    regs.other_index      = value[CLASS_W-1:0];
        REG_SILENCE_INDEX:  regs.silence_index    = value[CLASS_W-1:0];
        default: ;
      endcase
    endfunction

    // One accepted verdict: update run count and average, queue the expected result
    function void note_verdict(logic [CLASS_W-1:0] cls, logic [PROB_W-1:0] prob);
      result_t    want;
      int         cnt;
      bit [33:0]  w;
      bit [33:0]  acc;
      want = '0;
      if (cls == regs.other_index || cls == regs.silence_index) begin
        run_cnt  = '0;
        smoothed = '0;
      end else begin
        if (cls != last_cls) begin
          last_cls = cls;
          run_cnt  = '0;
          smoothed = '0;
        end
        cnt = int'(run_cnt) + 1;
        if (cnt > int'(regs.run_length)) cnt = int'(regs.run_length);
        // weights above one act as one
        w   = 34'((regs.ema_weight > Q16_ONE) ? Q16_ONE : regs.ema_weight);
        acc = w * prob + (Q16_ONE - w) * smoothed + ROUND_HALF;
        acc = acc >> 16;
        if (acc > 34'd65535) acc = 34'd65535;
        smoothed = acc[PROB_W-1:0];
        if (cnt >= int'(regs.run_length) && smoothed >= regs.detect_threshold) begin
          want.detected = 1'b1;
          want.cls      = cls;
          want.avg      = smoothed;
          cnt           = -int'(regs.holdoff_length);
          smoothed      = '0;
        end
        run_cnt = cnt[COUNT_W-1:0];
      end
      pending_results.push_back(want);
    endfunction

    function void check_result(logic detected, logic [CLASS_W-1:0] cls,
                               logic [PROB_W-1:0] avg);
      result_t want;
      n_checked++;
      if (pending_results.size() == 0) begin
        n_mismatches++;
        if (n_mismatches <= 10)
          $display("%0t: unexpected result detected=%0b class=%0d avg=%0d",
                   $realtime, detected, cls, avg);
      end else begin
        want = pending_results.pop_front();
        if (want.detected) n_detections++;
        if (want.detected !== detected || want.cls !== cls || want.avg !== avg) begin
          n_mismatches++;
          if (n_mismatches <= 10)
            $display("%0t: result %0d expected detected=%0b class=%0d avg=%0d, got %0b %0d %0d",
                     $realtime, n_checked, want.detected, want.cls, want.avg,
                     detected, cls, avg);
        end
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    out_tuser;
  logic                    cfg_psel = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]   cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  detection_scoreboard     sb;
  int                      send_idle_pct = 0;
  int                      recv_stall_pct = 0;
  int                      n_sent = 0;
  int                      n_settings = 1;
  int                      cycles = 0;

  keyword_detection_qualifier i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, sb.pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: check each transaction, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[3:0], out_tdata[19:4]);
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER || mode == IDLE_BOTH) ?
                     ((mode == IDLE_BOTH) ? 29 : 87) : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER || mode == IDLE_BOTH) ?
                     ((mode == IDLE_BOTH) ? 29 : 87) : 0;
  endtask

  // One verdict transaction; returns right after the accepting edge
  task automatic send_verdict(input logic [CLASS_W-1:0] cls, input logic [PROB_W-1:0] prob);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, prob, cls};
    do @(posedge clk); while (!in_tready);
    sb.note_verdict(cls, prob);
    n_sent++;
  endtask

  // APB write: setup, access, then the bus is released before returning
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Rewrite all registers once nothing is in flight
  task automatic write_cfg(input logic [CFG_DATA_W-1:0] weight, thresh, run, holdoff,
                           other, silence);
    drain();
    write_reg(REG_EMA_WEIGHT, weight);
    write_reg(REG_DETECT_THRESH, thresh);
    write_reg(REG_RUN_LENGTH, run);
    write_reg(REG_HOLDOFF_LENGTH, holdoff);
    write_reg(REG_OTHER_INDEX, other);
    write_reg(REG_SILENCE_INDEX, silence);
    n_settings++;
  endtask

  // Mostly runs of one keyword class with high probabilities, some broken by
  // ignored classes, plus fully random verdicts as noise
  task automatic random_traffic(input int budget);
    int               sent;
    int               len;
    int               extra;
    int               pick;
    logic [CLASS_W-1:0] cls;
    logic [PROB_W-1:0]  prob;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 75) begin
        do cls = CLASS_W'($urandom_range(0, 15));
        while (cls == sb.regs.other_index || cls == sb.regs.silence_index);
        extra = (sb.regs.holdoff_length > 8) ? 8 : int'(sb.regs.holdoff_length);
        len   = int'(sb.regs.run_length) + $urandom_range(0, extra + 3);
        if (len < 1) len = 1;
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 15)      prob = 16'hFFFF;
          else if (pick < 75) prob = PROB_W'($urandom_range(45000, 65535));
          else                prob = PROB_W'($urandom_range(0, 65535));
          if ($urandom_range(0, 99) < 4)
            send_verdict($urandom_range(0, 1) ? sb.regs.other_index : sb.regs.silence_index,
                         prob);
          else
            send_verdict(cls, prob);
          sent++;
        end
      end else begin
        send_verdict(CLASS_W'($urandom_range(0, 15)), PROB_W'($urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  task automatic run_phase(input idle_mode_t mode,
                           input logic [CFG_DATA_W-1:0] weight, thresh, run, holdoff,
                           other, silence, input int budget);
    write_cfg(weight, thresh, run, holdoff, other, silence);
    set_idling(mode);
    random_traffic(budget);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: both ignored classes, a long full-scale run, then a new class
    send_verdict(4'd0, 16'hFFFF);
    send_verdict(4'd1, 16'h0000);
    repeat (11) send_verdict(4'd15, 16'hFFFF);
    send_verdict(4'd2, 16'h0000);

    // Weight above one, zero run length, zero threshold, one shared ignored class
    write_cfg(32'h1FFFF, 32'd0, 32'd0, 32'd0, 32'd5, 32'd5);
    send_verdict(4'd5, 16'hFFFF);
    send_verdict(4'd0, 16'h0000);
    send_verdict(4'd1, 16'hFFFF);
    send_verdict(4'd15, 16'h8000);

    // Zero weight keeps the average at zero; count saturates at one
    write_cfg(32'd0, 32'hFFFF, 32'd1, 32'd255, 32'd15, 32'd14);
    repeat (2) send_verdict(4'd3, 16'hFFFF);
    send_verdict(4'd14, 16'h1234);

    // Full weight, top threshold, short run with hold-off after the detection
    write_cfg(32'h10000, 32'hFFFF, 32'd2, 32'd1, 32'd15, 32'd14);
    repeat (4) send_verdict(4'd4, 16'hFFFF);

    // Random phases across settings and idling modes
    run_phase(IDLE_NONE, 32'd19661, 32'd52429, 32'd10, 32'd10, 32'd0, 32'd1, 12);
    run_phase(IDLE_SENDER, 32'h10000, 32'hFFFF, 32'd1, 32'd0, 32'd15, 32'd15, 12);
    run_phase(IDLE_RECEIVER, $urandom_range(3000, 65536), $urandom_range(30000, 65535),
              $urandom_range(1, 12), $urandom_range(0, 12), $urandom_range(0, 15),
              $urandom_range(0, 15), 12);
    run_phase(IDLE_BOTH, 32'h1FFFF, 32'd0, 32'd3, 32'd255, 32'd7, 32'd9, 12);
    run_phase(IDLE_NONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd3, 32'd3, 12);
    run_phase(IDLE_SENDER, $urandom_range(3000, 65536), $urandom_range(30000, 65535),
              $urandom_range(1, 12), $urandom_range(0, 12), $urandom_range(0, 15),
              $urandom_range(0, 15), 12);
    run_phase(IDLE_RECEIVER, $urandom_range(3000, 65536), $urandom_range(30000, 65535),
              $urandom_range(1, 12), $urandom_range(0, 12), $urandom_range(0, 15),
              $urandom_range(0, 15), 12);
    // Longest run length and hold-off: one long run drives the count toward the top
    run_phase(IDLE_BOTH, 32'h10000, 32'd0, 32'd255, 32'd255, 32'd14, 32'd15, 200);
    run_phase(IDLE_BOTH, $urandom_range(3000, 65536), $urandom_range(30000, 65535),
              $urandom_range(1, 12), $urandom_range(0, 12), $urandom_range(0, 15),
              $urandom_range(0, 15), 12);

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d verdicts under %0d register settings and four idling modes;",
             n_sent, n_settings);
    $display("checked %0d results, %0d of them detections, %0d mismatches.",
             sb.n_checked, sb.n_detections, sb.n_mismatches);
    if (sb.n_mismatches == 0 && sb.pending_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
